### rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the motion energy detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a condition holds in the same cycle as its trigger.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that a condition holds in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/pmed_pkg.sv
// Shared types and constants of the PIR motion energy detector.
package pmed_pkg;

    localparam int WINDOW_LEN_DEF  = 15;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int SAMPLE_W = 16;
    localparam int LIGHT_W  = 10;
    localparam int THRESH_W = 11;
    localparam int MAG_W    = 8;
    localparam int MAG_MAX  = 128;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 11'd80;
    localparam logic [SAMPLE_W-1:0] BUSY_CODE       = 16'hFFFF;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_SEND   = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [SAMPLE_W-1:0] pir_sample;
        logic [LIGHT_W-1:0]  light_level;
    } pmed_in_t;

    typedef struct packed {
        logic [LIGHT_W-1:0] brightness_out;
        logic               motion_seen;
    } pmed_out_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pmed_q_stat_t;

endpackage

### rtl/pmed_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pmed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pmed_front.sv
// Front end: input handshake and classification of items into queue operations.
module pmed_front (
    input  logic                   item_valid,
    output logic                   item_ready,
    input  pmed_pkg::pmed_in_t     item,
    input  pmed_pkg::pmed_q_stat_t q_stat,
    output logic                   push,
    output pmed_pkg::pmed_in_t     push_op
);

    logic is_busy;

    // Drop converter busy codes here; they leave no trace in the state.
    assign is_busy    = (item.cmd == pmed_pkg::CMD_SAMPLE) &&
                        (item.pir_sample == pmed_pkg::BUSY_CODE);
    assign item_ready = !q_stat.full;
    assign push       = item_valid && item_ready && !is_busy;
    assign push_op    = item;

endmodule

### rtl/pmed_queue.sv
// Short FIFO that decouples the front end from the execution back end.
`include "assert_macros.svh"

module pmed_queue #(
    parameter int DEPTH = pmed_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  pmed_pkg::pmed_in_t     push_op,
    input  logic                   pop,
    output pmed_pkg::pmed_in_t     head,
    output pmed_pkg::pmed_q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pmed_pkg::pmed_in_t slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);

    `ASSERT_ALWAYS(a_queue_count_bound, clk, rst_n, count_reg <= CNT_FULL, "queue overflow")

endmodule

### rtl/pmed_back.sv
// Back end: DC offset tracking, deviation window, energy check and send results.
`include "assert_macros.svh"

module pmed_back #(
    parameter int WINDOW_LEN = pmed_pkg::WINDOW_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pmed_pkg::THRESH_W-1:0] cfg_wdata,
    input  pmed_pkg::pmed_q_stat_t        q_stat,
    input  pmed_pkg::pmed_in_t            head,
    output logic                          pop,
    output logic                          result_valid,
    input  logic                          result_ready,
    output pmed_pkg::pmed_out_t           result
);

    localparam int SAMPLE_W   = pmed_pkg::SAMPLE_W;
    localparam int LIGHT_W    = pmed_pkg::LIGHT_W;
    localparam int THRESH_W   = pmed_pkg::THRESH_W;
    localparam int MAG_W      = pmed_pkg::MAG_W;
    localparam int PTR_W      = $clog2(WINDOW_LEN);
    localparam int ENERGY_MAX = WINDOW_LEN * pmed_pkg::MAG_MAX;
    localparam int ENERGY_W   = $clog2(ENERGY_MAX + 1);
    localparam int CMP_W      = (ENERGY_W > THRESH_W) ? ENERGY_W : THRESH_W;
    localparam int SUM_W      = SAMPLE_W + 3;
    localparam int RECIP_W    = 20;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int Div5Shift  = 22;
    localparam logic [RECIP_W-1:0]  DIV5_RECIP = 20'd838861;
    localparam logic [PTR_W-1:0]    PTR_LAST   = PTR_W'(WINDOW_LEN - 1);
    localparam logic [ENERGY_W-1:0] ENERGY_TOP = ENERGY_W'(ENERGY_MAX);

    // Exact floor(x / 5) for x below 2**19 via multiply by reciprocal.
    function automatic logic [SAMPLE_W-1:0] div5(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(DIV5_RECIP);
        return prod[Div5Shift +: SAMPLE_W];
    endfunction

    logic [THRESH_W-1:0] threshold_reg;
    logic [SAMPLE_W-1:0] dc_reg, dc_next;
    logic [SUM_W-1:0]    dc_sum;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [WINDOW_LEN-1:0] ring_vld_reg;

    logic                x_valid_reg;
    logic                x_cmd_reg;
    logic [SAMPLE_W-1:0] x_sample_reg;
    logic [SAMPLE_W-1:0] x_dc_reg;
    logic [LIGHT_W-1:0]  x_light_reg;
    logic [PTR_W-1:0]    x_ptr_reg;
    logic                x_old_vld_reg;

    logic [ENERGY_W-1:0] energy_reg, energy_next;
    logic                sticky_reg;
    logic                result_valid_reg;
    pmed_pkg::pmed_out_t result_reg;

    logic             out_free, x_adv, x_take, x_wr, x_send;
    logic [MAG_W-1:0] ram_rdata, old_mag, dev, mag;
    logic             hit;

    // Execution stage handshake: a send needs room in the output register.
    assign out_free = !result_valid_reg || result_ready;
    assign x_adv    = x_valid_reg && ((x_cmd_reg == pmed_pkg::CMD_SAMPLE) || out_free);
    assign x_take   = !x_valid_reg || x_adv;
    assign pop      = !q_stat.empty && x_take;
    assign x_wr     = x_adv && (x_cmd_reg == pmed_pkg::CMD_SAMPLE);
    assign x_send   = x_adv && (x_cmd_reg == pmed_pkg::CMD_SEND);

    // Offset update at dequeue; loads the sample when the offset sits at zero.
    assign dc_sum = SUM_W'({dc_reg, 2'b00}) + SUM_W'(head.pir_sample);

    always_comb
    begin
        dc_next     = dc_reg;
        rd_ptr_next = rd_ptr_reg;
        if (pop && (head.cmd == pmed_pkg::CMD_SAMPLE))
        begin
            dc_next     = (dc_reg == '0) ? head.pir_sample : div5(dc_sum);
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    // Window entries hold magnitudes; an entry never written counts as zero.
    pmed_ram #(
        .WIDTH (MAG_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .clk   (clk),
        .we    (x_wr),
        .waddr (x_ptr_reg),
        .wdata (mag),
        .re    (pop),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign old_mag     = x_old_vld_reg ? ram_rdata : '0;
    assign dev         = x_sample_reg[MAG_W-1:0] - x_dc_reg[MAG_W-1:0];
    assign mag         = dev[MAG_W-1] ? (MAG_W'(0) - dev) : dev;
    assign energy_next = energy_reg - ENERGY_W'(old_mag) + ENERGY_W'(mag);
    assign hit         = CMP_W'(energy_next) >= CMP_W'(threshold_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= pmed_pkg::THRESHOLD_RESET;
            dc_reg           <= '0;
            rd_ptr_reg       <= '0;
            ring_vld_reg     <= '0;
            x_valid_reg      <= 1'b0;
            energy_reg       <= '0;
            sticky_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                threshold_reg <= cfg_wdata;
            end
            dc_reg     <= dc_next;
            rd_ptr_reg <= rd_ptr_next;
            if (x_take)
            begin
                x_valid_reg <= pop;
            end
            if (x_wr)
            begin
                ring_vld_reg[x_ptr_reg] <= 1'b1;
                energy_reg              <= energy_next;
                if (hit)
                begin
                    sticky_reg <= 1'b1;
                end
            end
            else if (x_send)
            begin
                sticky_reg <= 1'b0;
            end
            if (x_send)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            x_cmd_reg     <= head.cmd;
            x_sample_reg  <= head.pir_sample;
            x_dc_reg      <= dc_next;
            x_light_reg   <= head.light_level;
            x_ptr_reg     <= rd_ptr_reg;
            x_old_vld_reg <= ring_vld_reg[rd_ptr_reg];
        end
        if (x_send)
        begin
            result_reg.brightness_out <= x_light_reg;
            result_reg.motion_seen    <= sticky_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_IMPL(a_ring_no_collision, clk, rst_n, pop && x_wr, rd_ptr_reg != x_ptr_reg, "ring read and write collide")
    `ASSERT_NEXT(a_send_clears_flag, clk, rst_n, x_send, !sticky_reg, "motion flag not cleared by send")
    `ASSERT_ALWAYS(a_energy_bound, clk, rst_n, energy_reg <= ENERGY_TOP, "window energy out of range")

endmodule

### rtl/pir_motion_energy_detector_unit.sv
// Top level of the PIR motion energy detector.
// The unit takes transactions on the item channel: a converter sample
// (cmd low) or a send tick (cmd high). Samples move a DC offset toward the
// reading with a 4:1 weighted average, fold the deviation into a window of
// WINDOW_LEN byte-wide entries, and set a sticky motion flag once the summed
// window magnitude reaches motion_threshold. A send tick returns the
// brightness reading together with the flag and clears the flag; samples
// return nothing, and busy codes (all ones) are dropped at the door. Sustained
// rate is one transaction per cycle while the queue has room. The pace is set
// by the offset update loop, which does one multiply by the reciprocal of five
// per cycle. A send result leaves the queue through the execution and output
// registers. A queue of QUEUE_DEPTH entries sits between the front end and the
// execution back end, and a single output register holds a result while the
// consumer stalls, so input keeps flowing until the queue fills. The window is
// cleared at reset by per-entry valid bits; no clearing pass runs.
// Write motion_threshold through cfg_we/cfg_wdata only while the unit is idle.
module pir_motion_energy_detector_unit #(
    parameter int WINDOW_LEN  = pmed_pkg::WINDOW_LEN_DEF,
    parameter int QUEUE_DEPTH = pmed_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // item channel
    input  logic                          item_valid,
    output logic                          item_ready,
    input  pmed_pkg::pmed_in_t            item,
    // result channel
    output logic                          result_valid,
    input  logic                          result_ready,
    output pmed_pkg::pmed_out_t           result,
    // threshold register write
    input  logic                          cfg_we,
    input  logic [pmed_pkg::THRESH_W-1:0] cfg_wdata
);

    pmed_pkg::pmed_q_stat_t q_stat;
    pmed_pkg::pmed_in_t     push_op;
    pmed_pkg::pmed_in_t     head;
    logic                   push;
    logic                   pop;

    // Accept transactions and drop busy samples before they reach the queue.
    pmed_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_stat     (q_stat),
        .push       (push),
        .push_op    (push_op)
    );

    // Hold accepted work so either side can stall on its own.
    pmed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .q_stat  (q_stat)
    );

    // Track the offset, update the window energy and emit send results.
    pmed_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .q_stat       (q_stat),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the PIR motion energy detector unit.
module testbench;
    import pmed_pkg::*;

    localparam int WINDOW   = WINDOW_LEN_DEF;
    localparam int SETTLE   = 12;      // cycles to let a trailing sample retire
    localparam int LONG_HOLD = 300;    // receiver hold-off that backs the unit up

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    pmed_in_t            item         = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    pmed_out_t           result;
    logic                cfg_we       = 1'b0;
    logic [THRESH_W-1:0] cfg_wdata    = '0;

    // Transactions waiting for the driver, and send reports the unit still owes.
    pmed_in_t  sensor_items[$];
    pmed_out_t due_reports[$];

    // Shadow copy of the detector state.
    logic [THRESH_W-1:0] m_threshold = THRESHOLD_RESET;
    logic [SAMPLE_W-1:0] m_offset    = '0;
    logic [7:0]          m_ring[WINDOW];
    int                  m_pos       = 0;
    logic                m_sticky    = 1'b0;

    int error_count  = 0;
    int reports_seen = 0;

    pir_motion_energy_detector_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Advance the shadow detector by one accepted transaction; queue the report
    // that a send tick owes.
    function automatic void update_motion_model(pmed_in_t it);
        int unsigned weighted;
        int unsigned energy;
        pmed_out_t   rep;
        if (it.cmd == CMD_SEND)
        begin
            rep.brightness_out = it.light_level;
            rep.motion_seen    = m_sticky;
            due_reports.push_back(rep);
            m_sticky = 1'b0;
        end
        else if (it.pir_sample != BUSY_CODE)
        begin
            // Load the offset when it sits at zero, else pull it 1/5 toward the sample.
            if (m_offset == '0)
                m_offset = it.pir_sample;
            else
            begin
                weighted = m_offset * 4 + it.pir_sample;
                m_offset = SAMPLE_W'(weighted / 5);
            end
            m_ring[m_pos] = 8'(it.pir_sample - m_offset);
            m_pos = (m_pos == WINDOW - 1) ? 0 : m_pos + 1;
            // Magnitude of a signed byte; -128 counts as 128.
            energy = 0;
            for (int i = 0; i < WINDOW; i++)
                energy += m_ring[i][7] ? 256 - m_ring[i] : m_ring[i];
            if (energy >= m_threshold)
                m_sticky = 1'b1;
        end
    endfunction

    function automatic void note_error(string what, pmed_out_t want, pmed_out_t got);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s: expected brightness %0d motion %0b, got brightness %0d motion %0b",
                     $realtime, what, want.brightness_out, want.motion_seen,
                     got.brightness_out, got.motion_seen);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued transactions in bursts with random gaps. Hold
    // valid and payload steady until the unit takes the transaction.
    // ------------------------------------------------------------------
    int burst_left = 16;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            // Predict at the edge that accepts the transaction.
            if (item_valid && item_ready)
                update_motion_model(item);
            // Load the next transaction only once the slot is free.
            if (!item_valid || item_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (sensor_items.size() > 0)
                begin
                    item       <= sensor_items.pop_front();
                    item_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each report against the oldest owed one, and drive
    // result_ready from a stall pattern that changes every so often. Now and
    // then hold ready low for a long stretch so the unit fills up and stalls
    // its input while the driver keeps offering.
    // ------------------------------------------------------------------
    int        stall_mode   = 0;
    int        mode_left    = 50;
    int        hold_left    = 0;
    int        next_hold_at = 20;
    pmed_out_t owed;

    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                reports_seen++;
                if (due_reports.size() == 0)
                    note_error("report with none owed", '0, result);
                else
                begin
                    owed = due_reports.pop_front();
                    if (result.brightness_out !== owed.brightness_out ||
                        result.motion_seen !== owed.motion_seen)
                        note_error("report mismatch", owed, result);
                end
            end

            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            else
                mode_left--;

            if (hold_left == 0 && reports_seen >= next_hold_at)
            begin
                hold_left    = LONG_HOLD;
                next_hold_at = reports_seen + 120;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                case (stall_mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= ($urandom_range(0, 1) == 0);
                    2:       result_ready <= ($urandom_range(0, 3) == 0);
                    default: result_ready <= ($urandom_range(0, 7) != 0);
                endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_sample(logic [SAMPLE_W-1:0] value);
        pmed_in_t it;
        it.cmd         = CMD_SAMPLE;
        it.pir_sample  = value;
        it.light_level = LIGHT_W'($urandom);
        sensor_items.push_back(it);
    endtask

    task automatic queue_send(logic [LIGHT_W-1:0] light, logic [SAMPLE_W-1:0] junk);
        pmed_in_t it;
        it.cmd         = CMD_SEND;
        it.pir_sample  = junk;
        it.light_level = light;
        sensor_items.push_back(it);
    endtask

    // Mostly a steady level with noise of the given spread, plus level jumps,
    // busy codes, full-range samples and send ticks. Wild mode swings hard.
    task automatic queue_random_items(int count, int spread, bit wild);
        int level;
        int value;
        int pick;
        level = $urandom_range(0, 65534);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
                queue_send(LIGHT_W'($urandom_range(0, 1023)), SAMPLE_W'($urandom));
            else if (pick < 21)
                queue_sample(BUSY_CODE);
            else if (pick < 24 || (wild && pick < 70))
                queue_sample(SAMPLE_W'($urandom_range(0, 65534)));
            else if (pick < 26)
            begin
                level = $urandom_range(0, 65534);
                queue_sample(SAMPLE_W'(level));
            end
            else
            begin
                value = level + int'($urandom_range(0, 2 * spread)) - spread;
                if (value < 0)
                    value = 0;
                if (value > 65534)
                    value = 65534;
                queue_sample(SAMPLE_W'(value));
            end
        end
    endtask

    // Pause the sender until every owed report is back, then let a trailing
    // sample drain through the pipeline.
    task automatic wait_drained();
        while (sensor_items.size() > 0 || item_valid || due_reports.size() > 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_threshold(logic [THRESH_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        m_threshold = value;
        @(negedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < WINDOW; i++)
            m_ring[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset threshold: offset load, return of the offset to zero and reload,
        // field extremes, busy code, send ticks at both brightness ends.
        queue_send(10'd0, BUSY_CODE);
        queue_sample(16'd0);
        queue_sample(16'd1);
        queue_sample(16'd0);
        queue_sample(16'd300);
        queue_sample(16'd65534);
        queue_sample(16'd0);
        queue_sample(BUSY_CODE);
        queue_sample(16'd65534);
        queue_sample(16'd12345);
        queue_send(10'd1023, 16'd0);
        queue_send(10'd512, 16'h5555);
        queue_sample(16'h8000);
        queue_sample(16'h7FFF);
        queue_send(10'h2AA, 16'hAAAA);
        queue_random_items(300, 40, 1'b0);
        wait_drained();

        // Zero threshold: any sample flags motion, a busy code does not,
        // and a second send sees the flag cleared.
        write_threshold('0);
        queue_sample(16'd100);
        queue_send(10'd1, 16'd0);
        queue_send(10'd2, 16'd0);
        queue_sample(BUSY_CODE);
        queue_send(10'd3, 16'd0);
        queue_random_items(150, 8, 1'b0);
        wait_drained();

        // Thresholds at the top of the energy range and beyond it.
        write_threshold(11'd2047);
        queue_random_items(150, 200, 1'b1);
        wait_drained();
        write_threshold(11'd1920);
        queue_random_items(150, 200, 1'b1);
        wait_drained();

        for (int k = 0; k < 3; k++)
        begin
            write_threshold(THRESH_W'($urandom_range(10, 700)));
            queue_random_items(200, $urandom_range(2, 120), 1'b0);
            wait_drained();
        end

        write_threshold(THRESHOLD_RESET);
        queue_random_items(250, 30, 1'b0);
        wait_drained();

        if (error_count == 0)
            $display("PASS pir_motion_energy_detector_unit");
        else
            $display("FAIL pir_motion_energy_detector_unit");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("FAIL pir_motion_energy_detector_unit");
        $finish;
    end

endmodule

### pir_motion_energy_detector_unit.f
+incdir+rtl
rtl/pmed_pkg.sv
rtl/pmed_ram.sv
rtl/pmed_front.sv
rtl/pmed_queue.sv
rtl/pmed_back.sv
rtl/pir_motion_energy_detector_unit.sv
tb/sv/testbench.sv
